// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
// each macro assumes clk and the active-low synchronous reset rst_n are in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define HTW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define HTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HTW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/htw_pkg.sv =====
// shared types and constants for the tree-walk decoder
// no dependencies; used by htw_emit and huffman_tree_walk_decoder_core
package htw_pkg;

  localparam int NODE_COUNT = 511;
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int CNT_W      = 32;
  localparam int BIT_W      = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SYM_W-1:0] sym_t;

  // one node table entry
  typedef struct packed {
    idx_t right;
    idx_t left;
    logic leaf;
    sym_t sym;
  } node_t;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_DECODE  = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  // configuration register indexes
  localparam logic REG_ROOT_NODE    = 1'b0;
  localparam logic REG_SYMBOL_TOTAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_CUR,
    ST_CHILD,
    ST_FLUSH
  } state_t;

  // request from the walker to the result stage
  typedef struct packed {
    logic sym_push;
    logic flush;
    sym_t sym;
    logic done;
  } emit_req_t;

endpackage

// ===== rtl/huffman_tree_walk_decoder_core.sv =====
// huffman tree-walk decoder: node table in one single-port-read ram, walked msb first
// node write, restart and unused commands are taken in idle; a coded byte is walked bit by bit
// with one ram read per bit (two when a walk starts at an interior root or resumes at a byte start)
// and then closed by a flush; a stalled output holds the walk until the result stage is ready
// reset (rst_n low, synchronous) clears the configuration registers, walk progress and output valid;
// the node table is not cleared and holds garbage until written
`include "assert_macros.svh"

module huffman_tree_walk_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [8:0] node_index, [17:9] left_child, [26:18] right_child,
                                  // [27] leaf_mark, [35:28] leaf_symbol, [43:36] coded_byte,
                                  // [47:44] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] symbol
  output logic        out_tlast,  // last_of_byte
  output logic        out_tuser,  // [0] stream_done
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  htw_pkg::idx_t            root_r;
  logic [htw_pkg::CNT_W-1:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r  <= '0;
      total_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        htw_pkg::REG_ROOT_NODE:    root_r  <= cfg_wdata[htw_pkg::IDX_W-1:0];
        htw_pkg::REG_SYMBOL_TOTAL: total_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input field unpacking
  // ---------------------------------------------------------------------------
  htw_pkg::cmd_t  in_cmd;
  htw_pkg::idx_t  in_node_index;
  htw_pkg::node_t in_node;
  logic [7:0]     in_coded_byte;
  logic           in_acc;

  assign in_cmd        = htw_pkg::cmd_t'(in_tuser);
  assign in_node_index = in_tdata[8:0];
  assign in_node.left  = in_tdata[17:9];
  assign in_node.right = in_tdata[26:18];
  assign in_node.leaf  = in_tdata[27];
  assign in_node.sym   = in_tdata[35:28];
  assign in_coded_byte = in_tdata[43:36];

  // ---------------------------------------------------------------------------
  // walker state
  // ---------------------------------------------------------------------------
  htw_pkg::state_t           state_r, state_nxt;
  logic [7:0]                byte_r, byte_nxt;
  logic [htw_pkg::BIT_W-1:0] bit_r, bit_nxt;
  logic                      walk_open_r, walk_open_nxt;
  htw_pkg::idx_t             walk_node_r, walk_node_nxt;
  logic [htw_pkg::CNT_W-1:0] decoded_r, decoded_nxt;
  logic                      finished_r, finished_nxt;
  // cached entry of walk_node, valid only inside one byte (node writes happen between bytes)
  htw_pkg::node_t            ent_r, ent_nxt;
  logic                      ent_ok_r, ent_ok_nxt;
  // address of the last table read
  htw_pkg::idx_t             cur_r, cur_nxt;

  // ---------------------------------------------------------------------------
  // node table ram: written only in idle, read only while walking, so the
  // read and the write never touch the same entry in overlapping cycles
  // ---------------------------------------------------------------------------
  logic [$bits(htw_pkg::node_t)-1:0] node_mem [htw_pkg::NODE_COUNT];
  logic           mem_we;
  logic           rd_en;
  htw_pkg::idx_t  rd_addr;
  logic           rd_oor;
  htw_pkg::idx_t  rd_idx;
  htw_pkg::node_t rdata_r;
  logic           oor_r;

  assign rd_oor = rd_addr >= htw_pkg::IDX_W'(htw_pkg::NODE_COUNT);
  assign rd_idx = rd_oor ? '0 : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[in_node_index] <= in_node;
    end
    if (rd_en) begin
      rdata_r <= htw_pkg::node_t'(node_mem[rd_idx]);
      oor_r   <= rd_oor;
    end
  end

  // ---------------------------------------------------------------------------
  // shared walk terms
  // ---------------------------------------------------------------------------
  htw_pkg::node_t            entry;       // entry just read, an out-of-range node reads as zero
  logic                      bit_val;
  logic                      over;
  logic                      last_bit;
  htw_pkg::idx_t             child_cur;
  htw_pkg::idx_t             child_ent;
  logic                      root_leaf;   // walk starts at a root that is itself a leaf
  logic [htw_pkg::CNT_W-1:0] decoded_inc;
  logic                      sym_done;
  htw_pkg::emit_req_t        req;
  logic                      emit_ready;

  assign entry       = oor_r ? '0 : rdata_r;
  assign bit_val     = byte_r[bit_r];
  assign over        = finished_r || (decoded_r >= total_r);
  assign last_bit    = (bit_r == '0);
  assign child_cur   = bit_val ? entry.right : entry.left;
  assign child_ent   = bit_val ? ent_r.right : ent_r.left;
  assign root_leaf   = !walk_open_r && entry.leaf;
  assign decoded_inc = decoded_r + 1'b1;
  assign sym_done    = decoded_inc >= total_r;

  assign in_tready = (state_r == htw_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      htw_pkg::ST_IDLE: begin
        if (in_acc && in_cmd == htw_pkg::CMD_DECODE) begin
          state_nxt = htw_pkg::ST_BIT;
        end
      end
      htw_pkg::ST_BIT: begin
        priority if (over) begin
          state_nxt = htw_pkg::ST_FLUSH;
        end else if (walk_open_r && ent_ok_r) begin
          state_nxt = htw_pkg::ST_CHILD;
        end else begin
          state_nxt = htw_pkg::ST_CUR;
        end
      end
      htw_pkg::ST_CUR: begin
        if (!root_leaf) begin
          state_nxt = htw_pkg::ST_CHILD;
        end else if (emit_ready) begin
          state_nxt = last_bit ? htw_pkg::ST_FLUSH : htw_pkg::ST_BIT;
        end
      end
      htw_pkg::ST_CHILD: begin
        if (!entry.leaf || emit_ready) begin
          state_nxt = last_bit ? htw_pkg::ST_FLUSH : htw_pkg::ST_BIT;
        end
      end
      htw_pkg::ST_FLUSH: begin
        if (emit_ready) begin
          state_nxt = htw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = htw_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and ram control
  // ---------------------------------------------------------------------------
  always_comb begin
    byte_nxt      = byte_r;
    bit_nxt       = bit_r;
    walk_open_nxt = walk_open_r;
    walk_node_nxt = walk_node_r;
    decoded_nxt   = decoded_r;
    finished_nxt  = finished_r;
    ent_nxt       = ent_r;
    ent_ok_nxt    = ent_ok_r;
    cur_nxt       = cur_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    req           = '0;
    unique case (state_r)
      htw_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            htw_pkg::CMD_WRITE: begin
              mem_we = in_node_index < htw_pkg::IDX_W'(htw_pkg::NODE_COUNT);
            end
            htw_pkg::CMD_RESTART: begin
              walk_open_nxt = 1'b0;
              walk_node_nxt = '0;
              decoded_nxt   = '0;
              finished_nxt  = 1'b0;
            end
            htw_pkg::CMD_DECODE: begin
              byte_nxt   = in_coded_byte;
              bit_nxt    = '1;
              ent_ok_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      htw_pkg::ST_BIT: begin
        if (!over) begin
          rd_en = 1'b1;
          priority if (walk_open_r && ent_ok_r) begin
            rd_addr = child_ent;
          end else if (walk_open_r) begin
            rd_addr = walk_node_r;
          end else begin
            rd_addr = root_r;
          end
          cur_nxt = rd_addr;
        end
      end
      htw_pkg::ST_CUR: begin
        if (root_leaf) begin
          req.sym_push = 1'b1;
          req.sym      = entry.sym;
          req.done     = sym_done;
          if (emit_ready) begin
            decoded_nxt   = decoded_inc;
            finished_nxt  = finished_r || sym_done;
            walk_node_nxt = '0;
            bit_nxt       = bit_r - 1'b1;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = child_cur;
          cur_nxt = child_cur;
        end
      end
      htw_pkg::ST_CHILD: begin
        if (entry.leaf) begin
          req.sym_push = 1'b1;
          req.sym      = entry.sym;
          req.done     = sym_done;
          if (emit_ready) begin
            decoded_nxt   = decoded_inc;
            finished_nxt  = finished_r || sym_done;
            walk_open_nxt = 1'b0;
            walk_node_nxt = '0;
            ent_ok_nxt    = 1'b0;
            bit_nxt       = bit_r - 1'b1;
          end
        end else begin
          // walk continues from this interior node; keep its entry for the next bit
          walk_open_nxt = 1'b1;
          walk_node_nxt = cur_r;
          ent_nxt       = entry;
          ent_ok_nxt    = 1'b1;
          bit_nxt       = bit_r - 1'b1;
        end
      end
      htw_pkg::ST_FLUSH: begin
        req.flush = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htw_pkg::ST_IDLE;
      walk_open_r <= 1'b0;
      walk_node_r <= '0;
      decoded_r   <= '0;
      finished_r  <= 1'b0;
      ent_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_open_r <= walk_open_nxt;
      walk_node_r <= walk_node_nxt;
      decoded_r   <= decoded_nxt;
      finished_r  <= finished_nxt;
      ent_ok_r    <= ent_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    bit_r  <= bit_nxt;
    ent_r  <= ent_nxt;
    cur_r  <= cur_nxt;
  end

  // ---------------------------------------------------------------------------
  // result stage: pending symbol plus output register
  // ---------------------------------------------------------------------------
  htw_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .ready      (emit_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // a pushed symbol and a byte-end flush never share a cycle
  `HTW_ASSERT(a_push_xor_flush, !(req.sym_push && req.flush), "push and flush together")
  // the stream only ends after at least one symbol was counted
  `HTW_ASSERT_IMP(a_finished_count, finished_r, decoded_r != '0, "finished with zero count")
  // the symbol counter only steps by one or is cleared
  `HTW_ASSERT(a_count_step, $stable(decoded_r) || decoded_r == '0 || decoded_r == $past(decoded_r) + 32'd1, "count jump")

endmodule

// ===== rtl/htw_emit.sv =====
// result stage: holds one pending symbol until its last-of-byte flag is known
// depends on htw_pkg and assert_macros.svh
`include "assert_macros.svh"

module htw_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  htw_pkg::emit_req_t req,
  output logic               ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,   // [7:0] symbol
  output logic               out_tlast,   // last_of_byte
  output logic               out_tuser    // [0] stream_done
);

  logic              pend_valid_r, pend_valid_nxt;
  htw_pkg::sym_t     pend_sym_r;
  logic              pend_done_r;
  logic              out_valid_r, out_valid_nxt;
  htw_pkg::sym_t     out_sym_r;
  logic              out_last_r;
  logic              out_done_r;
  logic              out_free;
  logic              load_out;

  assign out_free = !out_valid_r || out_tready;
  assign ready    = !pend_valid_r || out_free;
  assign load_out = pend_valid_r && out_free && (req.sym_push || req.flush);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
    pend_valid_nxt = pend_valid_r;
    if (req.sym_push && ready) begin
      pend_valid_nxt = 1'b1;
    end else if (req.flush && ready) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sym_r  <= pend_sym_r;
      out_done_r <= pend_done_r;
      out_last_r <= req.flush;
    end
    if (req.sym_push && ready) begin
      pend_sym_r  <= req.sym;
      pend_done_r <= req.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  // the symbol that ends the stream always closes its byte
  `HTW_ASSERT_IMP(a_done_is_last, out_valid_r && out_done_r, out_last_r, "done item without last")
  // a flush with a pending symbol and a free slot shows a last item next cycle
  `HTW_ASSERT_NXT(a_flush_last, req.flush && pend_valid_r && out_free, out_tvalid && out_tlast, "flush lost")

endmodule
